@@ sv/ptd_pkg.sv @@
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int MAX_TASKS   = 16;
    localparam int NUM_ENTRIES = 16;
    localparam int ID_W        = $clog2(NUM_ENTRIES);
    localparam int USED_W      = ID_W + 1;
    localparam int TABLE_CAP   = (MAX_TASKS < NUM_ENTRIES) ? MAX_TASKS : NUM_ENTRIES;
    localparam int CNT_W       = 32;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_ADD     = 3'd1,
        OP_ENABLE  = 3'd2,
        OP_DISABLE = 3'd3,
        OP_READ    = 3'd4,
        OP_CLEAR   = 3'd5,
        OP_INIT    = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BAD_ID = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic              add;
        logic              walk;
        logic              set_en;
        logic              en_val;
        logic              clear_all;
        logic [ID_W-1:0]   addr;
        logic [CNT_W-1:0]  period;
        logic [CNT_W-1:0]  countdown;
        logic [CNT_W-1:0]  runs;
    } tbl_wr_t;

    typedef struct packed {
        logic              enabled;
        logic [CNT_W-1:0]  period;
        logic [CNT_W-1:0]  countdown;
        logic [CNT_W-1:0]  runs;
    } tbl_rd_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == '1) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

@@ sv/periodic_task_dispatcher.sv @@
`timescale 1ns / 1ps

// Periodic task dispatcher: a table of up to sixteen periodic tasks held in flops, served by
// one countdown unit under a small sequencer. A tick walks the tasks in use one entry per
// cycle through that unit, then reports each dispatched task in index order, one item per
// cycle while the output is not stalled, or a single result with no dispatch if none fired.
// in_ready is high only between items; a result waiting in the output register does not
// hold off the next item.
module periodic_task_dispatcher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      op,
    input  logic [3:0]                      task_id,
    input  logic [31:0]                     period,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic                            dispatched,
    output logic [3:0]                      out_task,
    output logic [31:0]                     task_runs,
    output logic [31:0]                     ticks_total,
    output logic [31:0]                     ticks_active,
    output logic                            last
);

    localparam int ID_W   = ptd_pkg::ID_W;
    localparam int USED_W = ptd_pkg::USED_W;
    localparam int CNT_W  = ptd_pkg::CNT_W;
    localparam int NE     = ptd_pkg::NUM_ENTRIES;

    ptd_pkg::state_t      state_reg, state_next;
    logic [USED_W-1:0]    used_reg, used_next;
    logic [USED_W-1:0]    walk_reg, walk_next;
    logic [NE-1:0]        hit_reg, hit_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]     active_reg, active_next;

    ptd_pkg::status_t     resp_status_reg, resp_status_next;
    logic [ID_W-1:0]      resp_task_reg, resp_task_next;
    logic [CNT_W-1:0]     resp_runs_reg, resp_runs_next;

    logic                 out_valid_reg, out_valid_next;
    ptd_pkg::status_t     out_status_reg, out_status_next;
    logic                 out_disp_reg, out_disp_next;
    logic [ID_W-1:0]      out_task_reg, out_task_next;
    logic [CNT_W-1:0]     out_runs_reg, out_runs_next;
    logic                 out_last_reg, out_last_next;
    logic [CNT_W-1:0]     out_total_reg;
    logic [CNT_W-1:0]     out_active_reg;
    logic                 out_load;

    ptd_pkg::tbl_wr_t     tbl_wr;
    ptd_pkg::tbl_rd_t     tbl_rd;
    logic [ID_W-1:0]      rd_addr;
    logic                 alu_hit;
    logic [CNT_W-1:0]     alu_count;
    logic [CNT_W-1:0]     alu_runs;

    logic                 out_free;
    logic                 accept;
    logic                 id_ok;
    logic [ID_W-1:0]      sel_idx;
    logic [NE-1:0]        sel_onehot;

    ptd_task_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd      (tbl_rd)
    );

    ptd_task_alu u_alu (
        .entry          (tbl_rd),
        .hit            (alu_hit),
        .countdown_next (alu_count),
        .runs_next      (alu_runs)
    );

    // lowest pending dispatch
    always_comb
    begin
        sel_idx = '0;
        for (int i = NE - 1; i >= 0; i--)
        begin
            if (hit_reg[i])
            begin
                sel_idx = ID_W'(i);
            end
        end
        sel_onehot = NE'(1) << sel_idx;
    end

    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign id_ok    = {1'b0, task_id} < used_reg;
    assign in_ready = (state_reg == ptd_pkg::S_IDLE);

    always_comb
    begin
        unique case (state_reg)
            ptd_pkg::S_WALK: rd_addr = walk_reg[ID_W-1:0];
            ptd_pkg::S_EMIT: rd_addr = sel_idx;
            default:         rd_addr = task_id;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        walk_next        = walk_reg;
        hit_next         = hit_reg;
        total_next       = total_reg;
        active_next      = active_reg;
        resp_status_next = resp_status_reg;
        resp_task_next   = resp_task_reg;
        resp_runs_next   = resp_runs_reg;

        out_load         = 1'b0;
        out_status_next  = out_status_reg;
        out_disp_next    = out_disp_reg;
        out_task_next    = out_task_reg;
        out_runs_next    = out_runs_reg;
        out_last_next    = out_last_reg;

        tbl_wr           = '0;
        tbl_wr.addr      = rd_addr;
        tbl_wr.period    = period;
        tbl_wr.countdown = alu_count;
        tbl_wr.runs      = alu_runs;

        unique case (state_reg)
            ptd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    resp_status_next = ptd_pkg::ST_OK;
                    resp_task_next   = '0;
                    resp_runs_next   = '0;
                    state_next       = ptd_pkg::S_RESP;
                    unique case (ptd_pkg::op_t'(op))
                        ptd_pkg::OP_TICK:
                        begin
                            total_next = ptd_pkg::sat_inc(total_reg);
                            hit_next   = '0;
                            walk_next  = '0;
                            state_next = ptd_pkg::S_WALK;
                        end
                        ptd_pkg::OP_ADD:
                        begin
                            if (used_reg >= USED_W'(ptd_pkg::TABLE_CAP))
                            begin
                                resp_status_next = ptd_pkg::ST_FULL;
                            end
                            else
                            begin
                                tbl_wr.add       = 1'b1;
                                tbl_wr.addr      = used_reg[ID_W-1:0];
                                tbl_wr.countdown = period;
                                tbl_wr.runs      = '0;
                                resp_task_next   = used_reg[ID_W-1:0];
                                used_next        = used_reg + USED_W'(1);
                            end
                        end
                        ptd_pkg::OP_ENABLE, ptd_pkg::OP_DISABLE:
                        begin
                            resp_task_next = task_id;
                            if (id_ok)
                            begin
                                tbl_wr.set_en = 1'b1;
                                tbl_wr.en_val = (ptd_pkg::op_t'(op) == ptd_pkg::OP_ENABLE);
                            end
                            else
                            begin
                                resp_status_next = ptd_pkg::ST_BAD_ID;
                            end
                        end
                        ptd_pkg::OP_READ:
                        begin
                            resp_task_next = task_id;
                            if (id_ok)
                            begin
                                resp_runs_next = tbl_rd.runs;
                            end
                            else
                            begin
                                resp_status_next = ptd_pkg::ST_BAD_ID;
                            end
                        end
                        ptd_pkg::OP_CLEAR:
                        begin
                            total_next  = '0;
                            active_next = '0;
                        end
                        ptd_pkg::OP_INIT:
                        begin
                            tbl_wr.clear_all = 1'b1;
                            used_next        = '0;
                            total_next       = '0;
                            active_next      = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ptd_pkg::S_WALK:
            begin
                if (walk_reg < used_reg)
                begin
                    tbl_wr.walk = 1'b1;
                    if (alu_hit)
                    begin
                        hit_next[walk_reg[ID_W-1:0]] = 1'b1;
                        if (hit_reg == '0)
                        begin
                            active_next = ptd_pkg::sat_inc(active_reg);
                        end
                    end
                    walk_next = walk_reg + USED_W'(1);
                end
                else if (hit_reg == '0)
                begin
                    state_next = ptd_pkg::S_RESP;
                end
                else
                begin
                    state_next = ptd_pkg::S_EMIT;
                end
            end

            ptd_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = ptd_pkg::ST_OK;
                    out_disp_next   = 1'b1;
                    out_task_next   = sel_idx;
                    out_runs_next   = tbl_rd.runs;
                    out_last_next   = ((hit_reg & ~sel_onehot) == '0);
                    hit_next        = hit_reg & ~sel_onehot;
                    if (out_last_next)
                    begin
                        state_next = ptd_pkg::S_IDLE;
                    end
                end
            end

            ptd_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = resp_status_reg;
                    out_disp_next   = 1'b0;
                    out_task_next   = resp_task_reg;
                    out_runs_next   = resp_runs_reg;
                    out_last_next   = 1'b1;
                    state_next      = ptd_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ptd_pkg::S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptd_pkg::S_IDLE;
            used_reg      <= '0;
            walk_reg      <= '0;
            hit_reg       <= '0;
            total_reg     <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            walk_reg      <= walk_next;
            hit_reg       <= hit_next;
            total_reg     <= total_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: output counters are sampled when the result is loaded
    always_ff @(posedge clk)
    begin
        resp_status_reg <= resp_status_next;
        resp_task_reg   <= resp_task_next;
        resp_runs_reg   <= resp_runs_next;
        if (out_load)
        begin
            out_status_reg  <= out_status_next;
            out_disp_reg    <= out_disp_next;
            out_task_reg    <= out_task_next;
            out_runs_reg    <= out_runs_next;
            out_last_reg    <= out_last_next;
            out_total_reg   <= total_reg;
            out_active_reg  <= active_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign dispatched   = out_disp_reg;
    assign out_task     = out_task_reg;
    assign task_runs    = out_runs_reg;
    assign ticks_total  = out_total_reg;
    assign ticks_active = out_active_reg;
    assign last         = out_last_reg;

endmodule

@@ sv/ptd_task_table.sv @@
`timescale 1ns / 1ps

module ptd_task_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ptd_pkg::tbl_wr_t            wr,
    input  logic [ptd_pkg::ID_W-1:0]    rd_addr,
    output ptd_pkg::tbl_rd_t            rd
);

    logic [ptd_pkg::CNT_W-1:0]       period_mem [ptd_pkg::NUM_ENTRIES];
    logic [ptd_pkg::CNT_W-1:0]       count_mem  [ptd_pkg::NUM_ENTRIES];
    logic [ptd_pkg::CNT_W-1:0]       runs_mem   [ptd_pkg::NUM_ENTRIES];
    logic [ptd_pkg::NUM_ENTRIES-1:0] en_reg;

    always_ff @(posedge clk)
    begin
        if (wr.add)
        begin
            period_mem[wr.addr] <= wr.period;
        end
        if (wr.add || wr.walk)
        begin
            count_mem[wr.addr] <= wr.countdown;
            runs_mem[wr.addr]  <= wr.runs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= '0;
        end
        else if (wr.clear_all)
        begin
            en_reg <= '0;
        end
        else if (wr.add)
        begin
            en_reg[wr.addr] <= 1'b1;
        end
        else if (wr.set_en)
        begin
            en_reg[wr.addr] <= wr.en_val;
        end
    end

    assign rd.enabled   = en_reg[rd_addr];
    assign rd.period    = period_mem[rd_addr];
    assign rd.countdown = count_mem[rd_addr];
    assign rd.runs      = runs_mem[rd_addr];

endmodule

@@ sv/ptd_task_alu.sv @@
`timescale 1ns / 1ps

module ptd_task_alu (
    input  ptd_pkg::tbl_rd_t              entry,
    output logic                          hit,
    output logic [ptd_pkg::CNT_W-1:0]     countdown_next,
    output logic [ptd_pkg::CNT_W-1:0]     runs_next
);

    logic [ptd_pkg::CNT_W-1:0] base;

    always_comb
    begin
        hit  = entry.enabled && (entry.countdown == '0);
        // reload on dispatch, then the same tick decrements a nonzero value
        base = hit ? entry.period : entry.countdown;
        countdown_next = (entry.enabled && (base != '0)) ? base - ptd_pkg::CNT_W'(1) : base;
        runs_next      = hit ? ptd_pkg::sat_inc(entry.runs) : entry.runs;
    end

endmodule
